FILE: sv/dks_pkg.sv
`default_nettype none

package dks_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned HalfW  = 28;
  localparam int unsigned CdW    = 2 * HalfW;
  localparam int unsigned RkeyW  = 48;
  localparam int unsigned Rounds = 16;
  localparam int unsigned RndW   = 4;
  localparam int unsigned RotW   = 2;

  localparam logic [RndW-1:0] LastRound = RndW'(Rounds - 1);

  typedef struct packed {
    logic [HalfW-1:0] c;
    logic [HalfW-1:0] d;
  } cd_t;

  // Head of the front-to-back queue.
  typedef struct packed {
    logic valid;
    cd_t  data;
  } head_t;

  localparam logic [6:0] Pc1Tab [CdW] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [RotW-1:0] RotTab [Rounds] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [5:0] Pc2Tab [RkeyW] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  function automatic cd_t pc1(input logic [KeyW-1:0] k);
    logic [CdW-1:0] r;
    r = '0;
    for (int i = 0; i < CdW; i++) begin
      r[CdW-1-i] = k[KeyW - int'(Pc1Tab[i])];
    end
    return cd_t'(r);
  endfunction

  function automatic logic [RkeyW-1:0] pc2(input cd_t cd);
    logic [CdW-1:0]   v;
    logic [RkeyW-1:0] r;
    v = cd;
    r = '0;
    for (int j = 0; j < RkeyW; j++) begin
      r[RkeyW-1-j] = v[CdW - int'(Pc2Tab[j])];
    end
    return r;
  endfunction

  function automatic logic [HalfW-1:0] rotl(input logic [HalfW-1:0] x,
                                           input logic [RotW-1:0] n);
    logic [HalfW-1:0] r;
    case (n)
      2'd1:    r = {x[HalfW-2:0], x[HalfW-1]};
      2'd2:    r = {x[HalfW-3:0], x[HalfW-1:HalfW-2]};
      default: r = x;
    endcase
    return r;
  endfunction

  function automatic logic [HalfW-1:0] rotr(input logic [HalfW-1:0] x,
                                           input logic [RotW-1:0] n);
    logic [HalfW-1:0] r;
    case (n)
      2'd1:    r = {x[0], x[HalfW-1:1]};
      2'd2:    r = {x[1:0], x[HalfW-1:2]};
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dks_front.sv
`default_nettype none

module dks_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [dks_pkg::KeyW-1:0] key_i,
  output dks_pkg::head_t              head_o,
  input  wire logic                   head_pop_i
);
  import dks_pkg::*;

  cd_t        mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en, rd_en;

  assign full   = (count_q == 2'd2);
  assign wr_en  = push && !full;
  assign rd_en  = head_pop_i && (count_q != 2'd0);

  assign head_o = '{valid: (count_q != 2'd0), data: mem_q[rd_ptr_q]};

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    count_d  = count_q;
    case ({wr_en, rd_en})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  // Split the key into its halves on the way in.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= pc1(key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dks_back.sv
`default_nettype none

module dks_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    decrypt_order_i,
  input  wire dks_pkg::head_t          head_i,
  output logic                         head_pop_o,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [dks_pkg::RkeyW-1:0]    round_key_o,
  output logic [dks_pkg::RndW-1:0]     round_index_o,
  output logic                         last_o
);
  import dks_pkg::*;

  cd_t              cd_q, cd_d;
  logic [RndW-1:0]  cnt_q;
  logic             out_valid_q;
  logic [RkeyW-1:0] rkey_q, rkey_d;
  logic [RndW-1:0]  idx_q;
  logic             last_q;
  logic             step;
  cd_t              src;
  cd_t              fwd;
  logic [RotW-1:0]  amt;

  // Round zero works straight off the queue head.
  assign src  = (cnt_q == '0) ? head_i.data : cd_q;
  assign step = ((cnt_q != '0) || head_i.valid) && (!out_valid_q || pop);
  assign head_pop_o = step && (cnt_q == '0);

  always_comb begin
    amt   = decrypt_order_i ? RotTab[LastRound - cnt_q] : RotTab[cnt_q];
    fwd.c = rotl(src.c, amt);
    fwd.d = rotl(src.d, amt);
    if (decrypt_order_i) begin
      // Halves after round 16 equal the loaded ones; walk back by rotating right.
      rkey_d = pc2(src);
      cd_d.c = rotr(src.c, amt);
      cd_d.d = rotr(src.d, amt);
    end else begin
      rkey_d = pc2(fwd);
      cd_d   = fwd;
    end
  end

  assign empty         = !out_valid_q;
  assign round_key_o   = rkey_q;
  assign round_index_o = idx_q;
  assign last_o        = last_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      cd_q   <= cd_d;
      rkey_q <= rkey_d;
      idx_q  <= cnt_q;
      last_q <= (cnt_q == LastRound);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        cnt_q       <= cnt_q + RndW'(1);
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/des_key_schedule_unit.sv
`default_nettype none

// Channel   | Handshake                          | Word
// ----------+------------------------------------+-----------------------------------
// key in    | push / full (take: push&!full)     | key_i[63:0]
// subkeys   | empty / pop (take: pop&!empty)     | round_key_o, round_index_o, last_o
// config    | cfg_valid_i / cfg_ready_o          | cfg_data_i (decrypt order)
//
// Each key yields 16 subkey words, one per clock while pop keeps up.
// A taken key's halves are registered in the queue; its first subkey is then
// registered in the output register, once that register is free.
// A two-entry queue holds split keys so the front keeps taking words while
// the back end drains; the output register stalls the round unit only.
// Reset is asynchronous, active low, and clears all control state.

module des_key_schedule_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [dks_pkg::KeyW-1:0] key_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [dks_pkg::RkeyW-1:0]     round_key_o,
  output logic [dks_pkg::RndW-1:0]      round_index_o,
  output logic                          last_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic                     cfg_data_i
);
  import dks_pkg::*;

  head_t head;
  logic  head_pop;
  logic  decrypt_order_q;

  // Config is always taken; only the low bit matters.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_order_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      decrypt_order_q <= cfg_data_i;
    end
  end

  // Front: take keys, apply the first permutation, queue the halves.
  dks_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .key_i      (key_i),
    .head_o     (head),
    .head_pop_i (head_pop)
  );

  // Back: rotate halves round by round and emit subkeys.
  dks_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .decrypt_order_i (decrypt_order_q),
    .head_i          (head),
    .head_pop_o      (head_pop),
    .empty           (empty),
    .pop             (pop),
    .round_key_o     (round_key_o),
    .round_index_o   (round_index_o),
    .last_o          (last_o)
  );

  // Last flag marks exactly the final round.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (round_index_o == LastRound)))
    else $error("last flag out of step with round index");

  // Back end only takes a queue entry that exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head.valid)
    else $error("queue popped while empty");

  // Mid-run, the next subkey follows right away with the next index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=>
      (!empty && (round_index_o == $past(round_index_o) + RndW'(1))))
    else $error("subkey run broken");

  // A new run always starts at index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_o) |=> (empty || (round_index_o == '0)))
    else $error("run did not restart at index zero");

endmodule

`default_nettype wire
